/* sv/abst_pkg.sv */
// Shared types, constants and per-channel tuning functions for the
// adaptive buffer size tuner. No dependencies.
`default_nettype none

package abst_pkg;

    // Field widths
    localparam int unsigned SizeW  = 27;
    localparam int unsigned BwW    = 32;
    localparam int unsigned StepW  = 4;
    localparam int unsigned DirW   = 2;
    localparam int unsigned CfgIdxW = 3;

    // Tuning direction codes
    localparam logic [DirW-1:0] DIR_NONE = 2'd0;
    localparam logic [DirW-1:0] DIR_UP   = 2'd1;
    localparam logic [DirW-1:0] DIR_DOWN = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_RECV_MIN   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RECV_MAX   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RECV_START = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SEND_MIN   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SEND_MAX   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SEND_START = 3'd5;

    // Register reset values
    localparam logic [SizeW-1:0] RST_MIN   = 27'd4096;
    localparam logic [SizeW-1:0] RST_MAX   = 27'd1048576;
    localparam logic [SizeW-1:0] RST_START = 27'd65536;

    // Step cap and fixed floor (the size unit is 4096 bytes: step << 12)
    localparam logic [StepW-1:0] STEP_CAP = 4'd8;
    localparam logic [16:0]      FLOOR    = 17'd4096;

    // State of one channel
    typedef struct packed {
        logic [SizeW-1:0] now;
        logic [DirW-1:0]  dir;
        logic [StepW-1:0] step;
    } t_chan;

    // Grow / shrink / hold decision: 20*|l - m| > m, exact
    function automatic logic [DirW-1:0] decide(logic [BwW-1:0] m, logic [BwW-1:0] l);
        logic            up;
        logic [BwW-1:0]  diff;
        logic [BwW+4:0]  scaled;
        logic [DirW-1:0] res;
        up     = (m < l);
        diff   = up ? (l - m) : (m - l);
        scaled = {1'b0, diff, 4'b0} + {3'b0, diff, 2'b0};
        if (scaled > {5'b0, m}) begin
            res = up ? DIR_UP : DIR_DOWN;
        end else begin
            res = DIR_NONE;
        end
        return res;
    endfunction

    // Step after a move in direction want
    function automatic logic [StepW-1:0] adv_step(t_chan cur, logic [DirW-1:0] want);
        logic [StepW-1:0] stp;
        if (cur.dir == want) begin
            if (cur.step == '0) begin
                stp = 4'd1;
            end else if (cur.step < STEP_CAP) begin
                stp = {cur.step[StepW-2:0], 1'b0};
            end else begin
                stp = cur.step;
            end
        end else begin
            stp = 4'd1;
        end
        return stp;
    endfunction

    // One tick of one channel
    function automatic t_chan tune(t_chan cur, logic [DirW-1:0] want,
                                   logic [SizeW-1:0] lo, logic [SizeW-1:0] hi);
        t_chan            nx;
        logic [StepW-1:0] stp;
        logic [SizeW:0]   up_sum;
        logic [16:0]      dec_floor;
        logic [15:0]      dec;
        stp       = adv_step(cur, want);
        dec       = {stp, 12'b0};
        up_sum    = {1'b0, cur.now} + {12'b0, dec};
        dec_floor = {1'b0, dec} + FLOOR;
        nx        = cur;
        unique case (want)
            DIR_UP: begin
                if (cur.now == hi) begin
                    nx.dir  = DIR_NONE;
                    nx.step = '0;
                end else begin
                    nx.dir  = DIR_UP;
                    nx.step = stp;
                    if (cur.now < hi) begin
                        if (up_sum > {1'b0, hi}) begin
                            nx.now  = hi;
                            nx.dir  = DIR_NONE;
                            nx.step = '0;
                        end else begin
                            nx.now = up_sum[SizeW-1:0];
                        end
                    end
                end
            end
            DIR_DOWN: begin
                if (cur.now == lo) begin
                    nx.dir  = DIR_NONE;
                    nx.step = '0;
                end else if (cur.now < {10'b0, dec_floor}) begin
                    // would drop under the floor: clamp to min
                    nx.now  = lo;
                    nx.dir  = DIR_NONE;
                    nx.step = '0;
                end else begin
                    nx.now  = cur.now - {11'b0, dec};
                    nx.dir  = DIR_DOWN;
                    nx.step = stp;
                end
            end
            default: begin
                nx.dir  = DIR_NONE;
                nx.step = '0;
            end
        endcase
        return nx;
    endfunction

endpackage

`default_nettype wire

/* sv/adaptive_buffer_size_tuner.sv */
// Adaptive buffer size tuner: two-stage pipeline, decision then state update.
// An input beat is registered as a decision in stage A, then the state update and result are registered in stage B.
// Throughput: one beat per cycle while the output is not stalled; the per-channel size/step
// update loop closes in the second stage, through the channel state registers.
// Reset (synchronous, active low): registers to defaults, sizes to start values,
// direction and step cleared, pipeline empty.
`default_nettype none

module adaptive_buffer_size_tuner
    import abst_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [BwW-1:0]     i_in_measured,
    input  wire logic [BwW-1:0]     i_in_limit,
    input  wire logic [BwW-1:0]     i_out_measured,
    input  wire logic [BwW-1:0]     i_out_limit,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [SizeW-1:0]        o_recv_size,
    output logic [SizeW-1:0]        o_send_size,
    // configuration write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [SizeW-1:0]   i_cfg_data
);

    // Configuration registers (start values go straight into the channel state)
    logic [SizeW-1:0] r_recv_min, r_recv_max;
    logic [SizeW-1:0] r_send_min, r_send_max;

    // Channel state
    t_chan r_recv, r_send;
    t_chan n_recv, n_send;

    // Stage A: registered decisions
    logic            r_a_valid;
    logic [DirW-1:0] r_a_want_recv, r_a_want_send;

    // Stage B: result register
    logic             r_b_valid;
    logic [SizeW-1:0] r_recv_size, r_send_size;

    logic in_acc, a_move, b_free, cfg_wr;

    // Handshake
    always_comb begin
        b_free     = !r_b_valid || !i_out_stall;
        a_move     = r_a_valid && b_free;
        o_in_stall = r_a_valid && !b_free;
        in_acc     = i_in_valid && !o_in_stall;
        cfg_wr     = i_cfg_valid && o_cfg_ready;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_b_valid;
    assign o_recv_size = r_recv_size;
    assign o_send_size = r_send_size;

    // Next channel state
    always_comb begin
        n_recv = tune(r_recv, r_a_want_recv, r_recv_min, r_recv_max);
        n_send = tune(r_send, r_a_want_send, r_send_min, r_send_max);
    end

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv_min   <= RST_MIN;
            r_recv_max   <= RST_MAX;
            r_send_min   <= RST_MIN;
            r_send_max   <= RST_MAX;
            r_recv       <= '{now: RST_START, dir: DIR_NONE, step: '0};
            r_send       <= '{now: RST_START, dir: DIR_NONE, step: '0};
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (b_free) begin
                r_b_valid <= 1'b0;
            end

            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_RECV_MIN:   r_recv_min <= i_cfg_data;
                    REG_RECV_MAX:   r_recv_max <= i_cfg_data;
                    REG_RECV_START: r_recv.now <= i_cfg_data;
                    REG_SEND_MIN:   r_send_min <= i_cfg_data;
                    REG_SEND_MAX:   r_send_max <= i_cfg_data;
                    REG_SEND_START: r_send.now <= i_cfg_data;
                    default: ;
                endcase
            end else if (a_move) begin
                r_recv <= n_recv;
                r_send <= n_send;
            end
        end
    end

    // Payload: decisions and results
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_want_recv <= decide(i_in_measured, i_in_limit);
            r_a_want_send <= decide(i_out_measured, i_out_limit);
        end
        if (a_move) begin
            r_recv_size <= n_recv.now;
            r_send_size <= n_send.now;
        end
    end

endmodule

`default_nettype wire

/* sv/abst_checker.sv */
// Port-level checker for the adaptive buffer size tuner, bound to the top level.
// Depends on abst_pkg for field widths.
`default_nettype none

module abst_checker
    import abst_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire logic [SizeW-1:0] o_recv_size,
    input wire logic [SizeW-1:0] o_send_size
);

    // A stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_recv_size) && $stable(o_send_size))
        else $error("result payload changed while stalled");

    // Input side only stalls when the result register is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without back pressure");

    // An accepted beat reaches the output via stages A and B unless stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("result beat missing after accepted input");

endmodule

bind adaptive_buffer_size_tuner abst_checker u_abst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_recv_size (o_recv_size),
    .o_send_size (o_send_size)
);

`default_nettype wire
